FILE: rtl/lfa_pkg.sv
// Shared constants, request/response codes and control types for the
// lowest-free identifier allocator. No dependencies.
`default_nettype none
package lfa_pkg;

   localparam int NUM_PIDS   = 128;
   localparam int OWNER_BITS = 16;

   localparam int PID_W   = 16;
   localparam int CNT_OUT_W = 8;
   localparam int IDX_W   = (NUM_PIDS > 1) ? $clog2(NUM_PIDS) : 1;
   localparam int CNT_W   = $clog2(NUM_PIDS + 1);

   // free search runs over groups of eight entries
   localparam int GRP_W    = 8;
   localparam int LOC_W    = 3;
   localparam int NUM_GRPS = (NUM_PIDS + GRP_W - 1) / GRP_W;
   localparam int GSEL_W   = (NUM_GRPS > 1) ? $clog2(NUM_GRPS) : 1;
   localparam int PAD_W    = NUM_GRPS * GRP_W;

   typedef enum logic {
      REQ_ALLOC   = 1'b0,
      REQ_RELEASE = 1'b1
   } lfa_req_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOT_HELD = 2'd2
   } lfa_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DONE
   } lfa_state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic eval;
      logic commit;
   } lfa_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } lfa_sts_type;

endpackage
`default_nettype wire

FILE: rtl/lfa_ifs.sv
// Valid/ready channel interfaces: request, response and register write.
// Depends on lfa_pkg.
`default_nettype none
interface lfa_req_if;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [lfa_pkg::PID_W-1:0] owner_id;
   logic [lfa_pkg::PID_W-1:0] pid_in;
   modport source (output valid, req_type, owner_id, pid_in, input ready);
   modport sink   (input valid, req_type, owner_id, pid_in, output ready);
endinterface

interface lfa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [lfa_pkg::PID_W-1:0]     pid_out;
   logic [lfa_pkg::PID_W-1:0]     released_owner;
   logic [lfa_pkg::CNT_OUT_W-1:0] in_use_count;
   modport source (output valid, status, pid_out, released_owner, in_use_count,
                   input ready);
   modport sink   (input valid, status, pid_out, released_owner, in_use_count,
                   output ready);
endinterface

interface lfa_csr_if;
   logic                      valid;
   logic                      ready;
   logic [lfa_pkg::PID_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]          wr_data,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: rtl/lfa_ctrl.sv
// Allocator controller: sequences capture, evaluation and commit.
// Depends on lfa_pkg.
`default_nettype none
module lfa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire lfa_pkg::lfa_sts_type sts,
   output      lfa_pkg::lfa_cmd_type cmd
);
   import lfa_pkg::*;

   lfa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EVAL;
         ST_EVAL: state_in = ST_DONE;
         ST_DONE: if (sts.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EVAL: cmd.eval = 1'b1;
         ST_DONE: cmd.commit = sts.out_free;
         default: ;
      endcase
   end

   a_commit_in_done: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> state_ff == ST_IDLE)
      else $error("commit did not return to idle");
   a_eval_follows_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.eval)
      else $error("evaluation did not follow capture");
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval || state_ff == ST_DONE) |-> !req_ready)
      else $error("request taken while busy");
endmodule
`default_nettype wire

FILE: rtl/lfa_dp.sv
// Allocator datapath: held bitmap, grouped free search, owner RAM, count and
// response register. Depends on lfa_pkg, lfa_ifs and lfa_ram.
`default_nettype none
module lfa_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   lfa_req_if.sink                   req_chan,
   lfa_rsp_if.source                 rsp_chan,
   lfa_csr_if.sink                   csr_chan,
   input  wire lfa_pkg::lfa_cmd_type cmd,
   output      lfa_pkg::lfa_sts_type sts
);
   import lfa_pkg::*;

   logic [PID_W-1:0]      pid_base_ff;
   logic                  req_type_ff;
   logic [PID_W-1:0]      owner_ff;
   logic [PID_W-1:0]      pid_in_ff;

   logic [NUM_PIDS-1:0]   held_ff, held_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic [NUM_GRPS-1:0]   grp_free_ff, grp_free_in;
   logic [LOC_W-1:0]      grp_loc_ff [NUM_GRPS];
   logic [LOC_W-1:0]      grp_loc_in [NUM_GRPS];
   logic                  rel_hit_ff, rel_hit_in;

   logic [PAD_W-1:0]      free_pad;
   logic [PID_W-1:0]      rel_diff;
   logic [IDX_W-1:0]      rel_idx;
   logic                  rel_in_range;
   logic [GSEL_W-1:0]     gsel;
   logic [IDX_W-1:0]      alloc_idx;
   logic                  alloc_found;
   logic                  is_release;
   logic                  out_free;

   logic                  rsp_valid_ff, rsp_valid_in;
   lfa_status_type        status_ff, status_in;
   logic [PID_W-1:0]      pid_out_ff, pid_out_in;
   logic [PID_W-1:0]      rel_owner_ff, rel_owner_in;

   logic                  ram_wr_en;
   logic [OWNER_BITS-1:0] ram_rd_data;

   assign csr_chan.ready = 1'b1;
   assign is_release     = (req_type_ff == REQ_RELEASE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_base_ff <= '0;
      end else if (csr_chan.valid) begin
         pid_base_ff <= csr_chan.data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_chan.req_type;
         owner_ff    <= req_chan.owner_id;
         pid_in_ff   <= req_chan.pid_in;
      end
   end

   // release lookup
   assign rel_diff     = pid_in_ff - pid_base_ff;
   assign rel_idx      = rel_diff[IDX_W-1:0];
   assign rel_in_range = (rel_diff < PID_W'(NUM_PIDS));

   // first level of free search: lowest free entry within each group
   assign free_pad = PAD_W'(~held_ff);

   always_comb begin
      for (int g = 0; g < NUM_GRPS; g++) begin
         grp_free_in[g] = |free_pad[g*GRP_W +: GRP_W];
         grp_loc_in[g]  = '0;
         for (int b = GRP_W - 1; b >= 0; b--) begin
            if (free_pad[g*GRP_W + b]) grp_loc_in[g] = LOC_W'(b);
         end
      end
      rel_hit_in = rel_in_range && held_ff[rel_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         grp_free_ff <= grp_free_in;
         grp_loc_ff  <= grp_loc_in;
         rel_hit_ff  <= rel_hit_in;
      end
   end

   // second level: lowest group with a free entry
   always_comb begin
      gsel = '0;
      for (int g = NUM_GRPS - 1; g >= 0; g--) begin
         if (grp_free_ff[g]) gsel = GSEL_W'(g);
      end
      alloc_found = |grp_free_ff;
      alloc_idx   = IDX_W'({gsel, grp_loc_ff[gsel]});
   end

   lfa_ram #(
      .WIDTH (OWNER_BITS),
      .DEPTH (NUM_PIDS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (alloc_idx),
      .wr_data (OWNER_BITS'(owner_ff)),
      .rd_en   (cmd.eval),
      .rd_addr (rel_idx),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_en = cmd.commit && !is_release && alloc_found;

   // commit: bitmap, count and response
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign sts.out_free = out_free;

   always_comb begin
      held_in      = held_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      pid_out_in   = pid_out_ff;
      rel_owner_in = rel_owner_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         pid_out_in   = '0;
         rel_owner_in = '0;
         if (is_release) begin
            if (rel_hit_ff) begin
               held_in[rel_idx] = 1'b0;
               count_in         = count_ff - CNT_W'(1);
               rel_owner_in     = PID_W'(ram_rd_data);
               status_in        = STATUS_OK;
            end else begin
               status_in = STATUS_NOT_HELD;
            end
         end else begin
            if (alloc_found) begin
               held_in[alloc_idx] = 1'b1;
               count_in           = count_ff + CNT_W'(1);
               pid_out_in         = pid_base_ff + PID_W'(alloc_idx);
               status_in          = STATUS_OK;
            end else begin
               status_in = STATUS_FULL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      pid_out_ff   <= pid_out_in;
      rel_owner_ff <= rel_owner_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.pid_out        = pid_out_ff;
   assign rsp_chan.released_owner = rel_owner_ff;
   assign rsp_chan.in_use_count   = CNT_OUT_W'(count_ff);

   a_count_matches_bitmap: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(held_ff)))
      else $error("held count out of step with bitmap");
   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("response overwritten");
   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit gave no response");
   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !is_release && !alloc_found) |-> (&held_ff))
      else $error("full reported with a free entry");
endmodule
`default_nettype wire

FILE: rtl/lowest_free_id_allocator.sv
// Top level of the lowest-free identifier allocator: controller plus datapath.
// Depends on lfa_pkg, lfa_ifs, lfa_ctrl and lfa_dp.
//
//   channel    dir  handshake          carries
//   req_chan   in   valid/ready        req_type, owner_id, pid_in
//   rsp_chan   out  valid/ready        status, pid_out, released_owner,
//                                      in_use_count
//   csr_chan   in   valid/ready (=1)   data -> pid_base
//
// Each request passes through three steps: accept, group-wise free search and owner
// RAM read, then commit into the response register. The owner RAM's
// registered read and the two-level free search call for the middle step.
// A new request is taken while a response waits; commit then holds until
// the response register empties.
// Synchronous reset clears the held bitmap, count and pid_base; no clearing
// pass is needed since owners are only read from held entries.
`default_nettype none
module lowest_free_id_allocator (
   input  wire logic clock,
   input  wire logic reset,
   lfa_req_if.sink   req_chan,
   lfa_rsp_if.source rsp_chan,
   lfa_csr_if.sink   csr_chan
);
   import lfa_pkg::*;

   lfa_cmd_type cmd;
   lfa_sts_type sts;
   logic        ctrl_ready;

   // request side: the controller owns ready
   lfa_req_if req_int ();

   assign req_int.valid    = req_chan.valid;
   assign req_int.req_type = req_chan.req_type;
   assign req_int.owner_id = req_chan.owner_id;
   assign req_int.pid_in   = req_chan.pid_in;
   assign req_int.ready    = ctrl_ready;
   assign req_chan.ready   = req_int.ready;

   lfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_int.valid),
      .req_ready (ctrl_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lfa_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_int),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .sts      (sts)
   );

   // at most one request in flight
   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("back-to-back accept");
endmodule
`default_nettype wire

FILE: tb/lowest_free_id_allocator_test.sv
// Self-checking testbench for lowest_free_id_allocator: directed and random
// allocate/release traffic, with a scoreboard that predicts every response.
// Depends on lfa_pkg, lfa_ifs and the allocator RTL.
`timescale 1ns / 100ps

module lowest_free_id_allocator_test;
   import lfa_pkg::*;

   // Expected contents of one response beat
   typedef struct packed {
      lfa_status_type status;
      logic [15:0]    pid;
      logic [15:0]    owner;
      logic [7:0]     count;
   } lfa_result_type;

   // Scoreboard: mirrors the identifier table and holds the responses that
   // are still owed by the block, oldest first.
   class lfa_scoreboard;
      logic [15:0]           pid_base;
      bit                    held [NUM_PIDS];
      logic [OWNER_BITS-1:0] owner_of [NUM_PIDS];
      int unsigned           held_total;
      lfa_result_type        awaited [$];
      int                    errors;

      function new();
         pid_base   = '0;
         held_total = 0;
         errors     = 0;
         foreach (held[i]) held[i] = 1'b0;
      endfunction

      function void set_base(logic [15:0] value);
         pid_base = value;
      endfunction

      // Work out the response to an accepted request and update the table
      function void note_request(lfa_req_type kind, logic [15:0] owner,
                                 logic [15:0] pid);
         lfa_result_type res;
         logic [15:0]    offset;
         int             slot;
         res.status = STATUS_OK;
         res.pid    = '0;
         res.owner  = '0;
         slot       = -1;
         if (kind == REQ_ALLOC) begin
            for (int i = NUM_PIDS - 1; i >= 0; i--)
               if (!held[i]) slot = i;
            if (slot < 0) begin
               res.status = STATUS_FULL;
            end else begin
               held[slot]     = 1'b1;
               owner_of[slot] = owner[OWNER_BITS-1:0];
               held_total++;
               offset  = slot[15:0];
               res.pid = pid_base + offset;
            end
         end else begin
            offset = pid - pid_base;
            if (offset < NUM_PIDS && held[offset]) begin
               held[offset] = 1'b0;
               res.owner    = owner_of[offset];
               if (held_total > 0) held_total--;
            end else begin
               res.status = STATUS_NOT_HELD;
            end
         end
         res.count = held_total[7:0];
         awaited.push_back(res);
      endfunction

      // Compare one accepted response with the oldest expectation
      function void check_response(logic [1:0] status, logic [15:0] pid,
                                   logic [15:0] owner, logic [7:0] count);
         lfa_result_type exp;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: response with none expected: status %0d pid %h owner %h count %0d",
                     $time, status, pid, owner, count);
         end else begin
            exp = awaited.pop_front();
            if (status !== exp.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
            end
            if (pid !== exp.pid) begin
               errors++;
               $display("%0t: pid_out expected %h actual %h", $time, exp.pid, pid);
            end
            if (owner !== exp.owner) begin
               errors++;
               $display("%0t: released_owner expected %h actual %h",
                        $time, exp.owner, owner);
            end
            if (count !== exp.count) begin
               errors++;
               $display("%0t: in_use_count expected %0d actual %0d",
                        $time, exp.count, count);
            end
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Random held entry index, or -1 when the table is empty
      function int pick_held();
         int cand [$];
         foreach (held[i])
            if (held[i]) cand.push_back(i);
         if (cand.size() == 0) return -1;
         return cand[$urandom_range(0, cand.size() - 1)];
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;   // set for a stretch in which neither side idles

   lfa_scoreboard sb;

   lfa_req_if req_chan ();
   lfa_rsp_if rsp_chan ();
   lfa_csr_if csr_chan ();

   lowest_free_id_allocator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Response side: check on every accepted beat, then pick ready for the
   // next edge. Roughly one stall in ten except during the calm stretch.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever @(posedge clock) begin
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            sb.check_response(rsp_chan.status, rsp_chan.pid_out,
                              rsp_chan.released_owner, rsp_chan.in_use_count);
         rsp_chan.ready <= calm || ($urandom_range(0, 99) >= 10);
      end
   end

   // Present one request and hold it until the block takes it. Called on a
   // rising edge; returns on the edge at which the request was accepted.
   task automatic send_request(input lfa_req_type kind, input logic [15:0] owner,
                               input logic [15:0] pid);
      if (!calm && $urandom_range(0, 99) < 10) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.owner_id <= owner;
      req_chan.pid_in   <= pid;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(kind, owner, pid);
   endtask

   // Stop sending and wait for every owed response; always waits on a clock
   // edge first so valid is never dropped and raised in the same step.
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Register write; only ever issued with the block idle
   task automatic write_base(input logic [15:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      sb.set_base(value);
      csr_chan.valid <= 1'b0;
   endtask

   // One random phase at a given pid_base. alloc_pct steers the table
   // towards full or towards empty. Releases mostly name a held identifier;
   // the rest are random or fall in the table or up to two entries past its edges.
   task automatic run_phase(input logic [15:0] base, input int alloc_pct,
                            input int n, input bit steady);
      int          hold_at;
      int          slot;
      lfa_req_type kind;
      logic [15:0] pid;
      logic [15:0] owner;
      logic [15:0] step;
      settle();
      write_base(base);
      calm    = steady;
      hold_at = $urandom_range(0, n - 1);
      for (int k = 0; k < n; k++) begin
         if (k == hold_at) settle();   // drain mid-phase once
         kind  = ($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_RELEASE;
         owner = 16'($urandom);
         pid   = 16'($urandom);
         if (kind == REQ_RELEASE) begin
            slot = sb.pick_held();
            if (slot >= 0 && $urandom_range(0, 99) < 85) begin
               step = slot[15:0];
               pid  = base + step;
            end else if ($urandom_range(0, 1) == 1) begin
               step = 16'($urandom_range(0, NUM_PIDS + 3));
               pid  = base + step - 16'd2;
            end
         end
         send_request(kind, owner, pid);
      end
      calm = 1'b0;
   endtask

   initial begin
      sb   = new();
      calm = 1'b0;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.req_type <= REQ_ALLOC;
      req_chan.owner_id <= '0;
      req_chan.pid_in   <= '0;
      csr_chan.valid    <= 1'b0;
      csr_chan.data     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: base zero, owner extremes, reuse of the lowest free slot,
      // releases of free entries and just outside the table
      write_base(16'h0000);
      send_request(REQ_ALLOC,   16'h0000, 16'h0000);
      send_request(REQ_ALLOC,   16'hFFFF, 16'h0000);
      send_request(REQ_ALLOC,   16'hA5A5, 16'h0000);
      send_request(REQ_RELEASE, 16'h0000, 16'h0001);
      send_request(REQ_RELEASE, 16'h0000, 16'h0001);   // already freed
      send_request(REQ_ALLOC,   16'h5A5A, 16'h0000);   // takes slot 1 again
      send_request(REQ_RELEASE, 16'h0000, 16'hFFFF);
      send_request(REQ_RELEASE, 16'h0000, 16'h0080);   // one past the table
      send_request(REQ_RELEASE, 16'h0000, 16'h007F);   // last entry, free
      send_request(REQ_RELEASE, 16'h0000, 16'h0000);
      send_request(REQ_RELEASE, 16'h0000, 16'h0002);
      send_request(REQ_RELEASE, 16'h0000, 16'h0001);

      // Directed: top base, release index wrapping below the base, ignored
      // fields carrying all ones
      settle();
      write_base(16'hFF80);
      send_request(REQ_ALLOC,   16'h8001, 16'h0000);
      send_request(REQ_ALLOC,   16'h7FFE, 16'h0000);
      send_request(REQ_RELEASE, 16'h0000, 16'h0000);
      send_request(REQ_RELEASE, 16'h0000, 16'hFF7F);
      send_request(REQ_RELEASE, 16'h0000, 16'hFF81);
      send_request(REQ_RELEASE, 16'h0000, 16'hFF80);
      send_request(REQ_ALLOC,   16'h1234, 16'hFFFF);
      send_request(REQ_RELEASE, 16'hFFFF, 16'hFF80);

      // Random phases: balanced, fill to full at the top base without random
      // idling, drain at base zero, then two more mixed settings
      run_phase(16'($urandom_range(0, 65408)), 50, 300, 1'b0);
      run_phase(16'hFF80,                      80, 350, 1'b1);
      run_phase(16'h0000,                      25, 350, 1'b0);
      run_phase(16'($urandom_range(0, 65408)), 65, 350, 1'b0);
      run_phase(16'($urandom_range(0, 65408)), 50, 350, 1'b0);

      settle();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: lowest_free_id_allocator.f
rtl/lfa_pkg.sv
rtl/lfa_ifs.sv
rtl/lfa_ram.sv
rtl/lfa_ctrl.sv
rtl/lfa_dp.sv
rtl/lowest_free_id_allocator.sv
tb/lowest_free_id_allocator_test.sv
